FILE: hw/rtl/gpsc_pkg.sv
// Shared types, constants and the command decoder for the game pad serial responder.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package gpsc_pkg;

  // Number of pad ports and the width of a pad index.
  localparam int PAD_PORTS = 2;
  localparam int PAD_W     = (PAD_PORTS > 1) ? $clog2(PAD_PORTS) : 1;

  // Stream widths.
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  // Configuration register indexes and widths.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 15;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_DEADZONE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_DEADZONE = 8'd1;
  localparam logic [CFG_DATA_W-1:0]  LEFT_DEADZONE_RST  = 15'd7849;
  localparam logic [CFG_DATA_W-1:0]  RIGHT_DEADZONE_RST = 15'd8689;

  // Reply bytes and console command characters.
  localparam logic [7:0] REPLY_IDLE     = 8'hff;
  localparam logic [7:0] ID_ANALOG_NAT  = 8'h79;
  localparam logic [7:0] ID_ANALOG      = 8'h71;
  localparam logic [7:0] ID_DIGITAL     = 8'h41;
  localparam logic [7:0] CHAR_Z         = 8'h5a;
  localparam logic [7:0] CHAR_A         = 8'h41;
  localparam logic [7:0] CHAR_B         = 8'h42;
  localparam logic [7:0] CHAR_C         = 8'h43;
  localparam logic [7:0] CHAR_D         = 8'h44;
  localparam logic [7:0] CHAR_E         = 8'h45;
  localparam logic [7:0] CHAR_M         = 8'h4d;
  localparam logic [7:0] CHAR_O         = 8'h4f;
  localparam logic [7:0] TRIGGER_MASK   = 8'he0;
  localparam logic [15:0] BUTTON_MASK   = 16'hfcff;
  localparam logic [15:0] BUTTONS_UP    = 16'hffff;
  localparam logic [7:0] STICK_CENTER   = 8'd128;

  // Action codes carried in tuser.
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_EXCHANGE = 1'b1;

  // Latched command.
  typedef enum logic [2:0] {
    CMD_UNKNOWN      = 3'd0,
    CMD_QUERY_ANALOG = 3'd1,
    CMD_READ_DATA    = 3'd2,
    CMD_CONFIG       = 3'd3,
    CMD_SET_MODE     = 3'd4,
    CMD_QUERY_MODEL  = 3'd5,
    CMD_VIBRATION    = 3'd6,
    CMD_NATIVE       = 3'd7
  } cmd_t;

  // One input beat, unpacked.
  typedef struct packed {
    logic        action;
    logic        pad_select;
    logic [7:0]  cmd_byte;
    logic [15:0] button_bits;
    logic [7:0]  left_trigger;
    logic [7:0]  right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic        pad_connected;
  } item_t;

  // Map the first command byte of a transaction to a handler.
  function automatic cmd_t decode_cmd(input logic [7:0] v);
    cmd_t c;
    unique case (v)
      CHAR_A:  c = CMD_QUERY_ANALOG;
      CHAR_B:  c = CMD_READ_DATA;
      CHAR_C:  c = CMD_CONFIG;
      CHAR_D:  c = CMD_SET_MODE;
      CHAR_E:  c = CMD_QUERY_MODEL;
      CHAR_M:  c = CMD_VIBRATION;
      CHAR_O:  c = CMD_NATIVE;
      default: c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/gpsc_stick_conv.sv
// Converts one signed stick axis to a pad stick byte with a deadzone.
// Depends on gpsc_pkg.
`timescale 1ns / 1ps

module gpsc_stick_conv
  import gpsc_pkg::*;
(
  input  logic signed [15:0]      axis,
  input  logic [CFG_DATA_W-1:0]   deadzone,
  output logic [7:0]              stick_byte
);

  logic [15:0] magnitude;

  // Magnitude fits 16 unsigned bits, including the most negative axis value.
  assign magnitude = axis[15] ? 16'(-axis) : 16'(axis);

  // Inside the deadzone the stick is centered; otherwise high byte plus 128.
  always_comb begin
    if (magnitude < {1'b0, deadzone}) begin
      stick_byte = STICK_CENTER;
    end else begin
      stick_byte = {~axis[15], axis[14:8]};
    end
  end

endmodule

FILE: hw/rtl/gpsc_engine.sv
// Per-byte transaction engine: pad state, byte position, command handlers and reply.
// Depends on gpsc_pkg and gpsc_stick_conv.
`timescale 1ns / 1ps

module gpsc_engine
  import gpsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  item_t                 item,
  input  logic [CFG_DATA_W-1:0] left_deadzone,
  input  logic [CFG_DATA_W-1:0] right_deadzone,
  output logic [7:0]            reply
);

  // Pad state.
  logic [15:0]          button_word [PAD_PORTS];
  logic [7:0]           stick_bytes [PAD_PORTS][4];
  logic                 analog_mode [PAD_PORTS];
  logic                 native_mode [PAD_PORTS];
  // Transaction state.
  logic [PAD_W-1:0]     current_pad;
  logic                 in_txn;
  logic [7:0]           byte_pos;
  cmd_t                 latched_cmd;
  logic                 config_reads_data;

  // Next values and write strobes.
  logic [PAD_W-1:0]     current_pad_next;
  logic                 in_txn_next;
  logic [7:0]           byte_pos_next;
  cmd_t                 latched_cmd_next;
  logic                 config_reads_data_next;
  logic                 latch_inputs;
  logic                 analog_wr;
  logic                 native_set;

  logic [7:0]           pos_inc;
  logic [7:0]           idx;
  logic [15:0]          live_buttons;
  logic [15:0]          button_live;
  logic [7:0]           stick_conv [4];
  logic [7:0]           stick_live [4];
  logic [7:0]           read_reply;
  logic [7:0]           mode_id;

  // Stick conversion for left x, left y, right x and right y.
  gpsc_stick_conv u_conv_lx (.axis(item.left_x),  .deadzone(left_deadzone),
                             .stick_byte(stick_conv[0]));
  gpsc_stick_conv u_conv_ly (.axis(item.left_y),  .deadzone(left_deadzone),
                             .stick_byte(stick_conv[1]));
  gpsc_stick_conv u_conv_rx (.axis(item.right_x), .deadzone(right_deadzone),
                             .stick_byte(stick_conv[2]));
  gpsc_stick_conv u_conv_ry (.axis(item.right_y), .deadzone(right_deadzone),
                             .stick_byte(stick_conv[3]));

  // Live inputs in stored form: active-low buttons with L2/R2 from the triggers.
  always_comb begin
    live_buttons    = item.button_bits & BUTTON_MASK;
    live_buttons[8] = |(item.left_trigger & TRIGGER_MASK);
    live_buttons[9] = |(item.right_trigger & TRIGGER_MASK);
    button_live     = item.pad_connected ? ~live_buttons : BUTTONS_UP;
    for (int k = 0; k < 4; k++) begin
      stick_live[k] = item.pad_connected ? stick_conv[k] : STICK_CENTER;
    end
  end

  // Byte position, saturating, and the handler index after the two header bytes.
  assign pos_inc = (byte_pos == 8'hff) ? byte_pos : byte_pos + 8'd1;
  assign idx     = pos_inc - 8'd3;

  assign mode_id = analog_mode[current_pad]
                   ? (native_mode[current_pad] ? ID_ANALOG_NAT : ID_ANALOG)
                   : ID_DIGITAL;

  // Read-data reply; byte zero shows the freshly latched buttons.
  always_comb begin
    unique case (idx)
      8'd0:    read_reply = button_live[7:0];
      8'd1:    read_reply = button_word[current_pad][15:8];
      8'd2:    read_reply = stick_bytes[current_pad][2];
      8'd3:    read_reply = ~stick_bytes[current_pad][3];
      8'd4:    read_reply = stick_bytes[current_pad][0];
      8'd5:    read_reply = ~stick_bytes[current_pad][1];
      default: read_reply = REPLY_IDLE;
    endcase
  end

  // Reply and next-state selection for one beat.
  always_comb begin
    reply                  = REPLY_IDLE;
    current_pad_next       = current_pad;
    in_txn_next            = in_txn;
    byte_pos_next          = byte_pos;
    latched_cmd_next       = latched_cmd;
    config_reads_data_next = config_reads_data;
    latch_inputs           = 1'b0;
    analog_wr              = 1'b0;
    native_set             = 1'b0;
    if (item.action == ACT_START) begin
      current_pad_next = (PAD_PORTS > 1) ? PAD_W'(item.pad_select) : '0;
      byte_pos_next    = 8'd0;
      in_txn_next      = 1'b1;
    end else if (in_txn) begin
      byte_pos_next = pos_inc;
      if (pos_inc == 8'd1) begin
        latched_cmd_next = decode_cmd(item.cmd_byte);
        reply            = mode_id;
      end else if (pos_inc == 8'd2) begin
        reply = CHAR_Z;
      end else begin
        unique case (latched_cmd)
          CMD_QUERY_ANALOG: begin
            reply = 8'd0;
            if (native_mode[current_pad]) begin
              unique case (idx)
                8'd0, 8'd1: reply = 8'hff;
                8'd2:       reply = 8'd3;
                8'd5:       reply = CHAR_Z;
                default:    reply = 8'd0;
              endcase
            end
          end
          CMD_READ_DATA: begin
            latch_inputs = (idx == 8'd0);
            reply        = read_reply;
          end
          CMD_CONFIG: begin
            if (idx == 8'd0 && item.cmd_byte == 8'd0) begin
              config_reads_data_next = 1'b0;
            end else if (idx == 8'd0 && item.cmd_byte == 8'd1) begin
              config_reads_data_next = 1'b1;
            end
            latch_inputs = config_reads_data_next && (idx == 8'd0);
            reply        = config_reads_data_next ? read_reply : 8'd0;
          end
          CMD_SET_MODE: begin
            // Only the mode byte changes what later replies report.
            analog_wr = (idx == 8'd0);
            reply     = 8'd0;
          end
          CMD_QUERY_MODEL: begin
            unique case (idx)
              8'd0, 8'd4: reply = 8'd1;
              8'd1:       reply = 8'd2;
              8'd2:       reply = analog_mode[current_pad] ? 8'd1 : 8'd0;
              8'd3:       reply = native_mode[current_pad] ? 8'd1 : 8'd2;
              default:    reply = 8'd0;
            endcase
          end
          CMD_VIBRATION: begin
            reply = (idx <= 8'd1) ? item.cmd_byte : REPLY_IDLE;
          end
          CMD_NATIVE: begin
            native_set = (idx == 8'd5);
            reply      = native_set ? CHAR_Z : 8'd0;
          end
          default: begin
            reply = 8'd0;
          end
        endcase
      end
    end
  end

  // Transaction state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_pad       <= '0;
      in_txn            <= 1'b0;
      byte_pos          <= 8'd0;
      latched_cmd       <= CMD_UNKNOWN;
      config_reads_data <= 1'b0;
    end else if (fire) begin
      current_pad       <= current_pad_next;
      in_txn            <= in_txn_next;
      byte_pos          <= byte_pos_next;
      latched_cmd       <= latched_cmd_next;
      config_reads_data <= config_reads_data_next;
    end
  end

  // Per-pad state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PAD_PORTS; p++) begin
        button_word[p] <= BUTTONS_UP;
        analog_mode[p] <= 1'b1;
        native_mode[p] <= 1'b1;
        for (int k = 0; k < 4; k++) begin
          stick_bytes[p][k] <= STICK_CENTER;
        end
      end
    end else if (fire) begin
      if (latch_inputs) begin
        button_word[current_pad] <= button_live;
        for (int k = 0; k < 4; k++) begin
          stick_bytes[current_pad][k] <= stick_live[k];
        end
      end
      if (analog_wr) begin
        analog_mode[current_pad] <= (item.cmd_byte == 8'd1);
      end
      if (native_set) begin
        native_mode[current_pad] <= 1'b1;
      end
    end
  end

  // A byte position is only held inside a transaction.
  a_pos_needs_txn: assert property (@(posedge clk) disable iff (rst)
    !in_txn |-> byte_pos == 8'd0)
    else $error("byte position set outside a transaction");

  // A start beat opens a transaction at position zero.
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == ACT_START |=> in_txn && byte_pos == 8'd0)
    else $error("start beat did not open a transaction");

  // A poll with no open transaction replies idle and leaves the position alone.
  a_poll_no_txn: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == ACT_EXCHANGE && !in_txn |-> reply == REPLY_IDLE)
    else $error("poll before start did not reply idle");

  // An exchange inside a transaction always moves off position zero.
  a_exchange_advances: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == ACT_EXCHANGE && in_txn |=> byte_pos != 8'd0)
    else $error("exchange did not advance the byte position");

endmodule

FILE: hw/rtl/game_pad_serial_command_responder.sv
// Top level of the game pad serial responder: stream ports, input and output registers,
// deadzone configuration registers. Depends on gpsc_pkg and gpsc_engine.
`timescale 1ns / 1ps

// Usage:
//   The slave stream (s_*) carries one beat per console action. tuser bit 0 selects
//   a start beat (0) that picks a pad port and restarts the byte count, or an
//   exchange beat (1) that carries one command byte plus the live pad inputs.
//   Every beat returns exactly one reply byte on the master stream (m_*).
//   The config channel (cfg_*) writes the left and right stick deadzones; it is
//   always ready and should be written while no beats are in flight.
// Path: a beat is registered in the input register on acceptance, and its reply is
//   registered in the reply register when the beat moves on.
// Throughput: one beat per cycle while m_tready stays high; the per-byte handler is a
//   short case selection between the input register and the reply register.
// Reset: rst (synchronous, active high) empties both registers, restores the
//   deadzones and puts every pad back to analog native mode with buttons released
//   and sticks centered, with no transaction open.
// Stall: when m_tready is low the reply holds; one more beat is taken into the
//   input register, after which s_tready drops until the reply is taken.
module game_pad_serial_command_responder
  import gpsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata from bit 0: cmd_byte[7:0], button_bits[23:8], left_trigger[31:24],
  // right_trigger[39:32], left_x[55:40], left_y[71:56], right_x[87:72],
  // right_y[103:88], pad_connected[104], zero fill[111:105]
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // tuser from bit 0: action[0], pad_select[1]
  input  logic [IN_USER_W-1:0]   s_tuser,
  // Reply stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata from bit 0: reply_byte[7:0]
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  item_t                 item;
  logic                  in_valid;
  logic                  advance;
  logic [7:0]            reply;
  logic [7:0]            reply_reg;
  logic                  out_valid;
  logic [CFG_DATA_W-1:0] left_deadzone;
  logic [CFG_DATA_W-1:0] right_deadzone;

  // The input register moves on whenever the reply register is free or being drained.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.action        <= s_tuser[0];
      item.pad_select    <= s_tuser[1];
      item.cmd_byte      <= s_tdata[7:0];
      item.button_bits   <= s_tdata[23:8];
      item.left_trigger  <= s_tdata[31:24];
      item.right_trigger <= s_tdata[39:32];
      item.left_x        <= s_tdata[55:40];
      item.left_y        <= s_tdata[71:56];
      item.right_x       <= s_tdata[87:72];
      item.right_y       <= s_tdata[103:88];
      item.pad_connected <= s_tdata[104];
    end
  end

  // Per-byte engine.
  gpsc_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .item           (item),
    .left_deadzone  (left_deadzone),
    .right_deadzone (right_deadzone),
    .reply          (reply)
  );

  // Reply register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reply_reg <= reply;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = reply_reg;

  // Deadzone registers; writes to other indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_deadzone  <= LEFT_DEADZONE_RST;
      right_deadzone <= RIGHT_DEADZONE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LEFT_DEADZONE) begin
        left_deadzone <= cfg_data;
      end
      if (cfg_index == REG_RIGHT_DEADZONE) begin
        right_deadzone <= cfg_data;
      end
    end
  end

endmodule

FILE: sim/game_pad_serial_command_responder_test.sv
// Self-checking testbench for the game pad serial responder: a pad-link predictor in a small
// scoreboard class, stream drivers with random gaps, and deadzone configuration phases.
// Depends on gpsc_pkg and game_pad_serial_command_responder from hw/rtl.
`timescale 1ns / 1ps

module game_pad_serial_command_responder_test;
  import gpsc_pkg::*;

  // Predicts the reply byte of every accepted beat and checks the replies in order.
  class pad_reply_scoreboard;
    logic [CFG_DATA_W-1:0] dz_left;
    logic [CFG_DATA_W-1:0] dz_right;
    logic [15:0] buttons [PAD_PORTS];
    logic [7:0]  sticks [4*PAD_PORTS];
    bit          analog [PAD_PORTS];
    bit          native [PAD_PORTS];
    bit          locked [PAD_PORTS];
    bit          vib_on [PAD_PORTS];
    int unsigned pad;
    bit          in_txn;
    int unsigned pos;
    cmd_t        cmd;
    bit          cfg_reads;
    logic [7:0]  replies_due [$];
    int unsigned faults;
    int unsigned checked;

    function new();
      dz_left   = LEFT_DEADZONE_RST;
      dz_right  = RIGHT_DEADZONE_RST;
      for (int i = 0; i < PAD_PORTS; i++) begin
        buttons[i] = BUTTONS_UP;
        analog[i]  = 1'b1;
        native[i]  = 1'b1;
        locked[i]  = 1'b0;
        vib_on[i]  = 1'b1;
      end
      for (int i = 0; i < 4*PAD_PORTS; i++) sticks[i] = STICK_CENTER;
      pad       = 0;
      in_txn    = 1'b0;
      pos       = 0;
      cmd       = CMD_UNKNOWN;
      cfg_reads = 1'b0;
      faults    = 0;
      checked   = 0;
    endfunction

    // Axis inside the deadzone reads centered, otherwise high byte offset by 128.
    function logic [7:0] axis_byte(logic signed [15:0] a, logic [CFG_DATA_W-1:0] dz);
      int mag;
      mag = a;
      if (mag < 0) mag = -mag;
      if (mag < int'(dz)) return STICK_CENTER;
      return a[15:8] + 8'd128;
    endfunction

    // Read-data handler; data byte 0 latches the live inputs of the current pad.
    function logic [7:0] read_pad(int unsigned idx, item_t it);
      logic [15:0] b;
      int unsigned base;
      base = pad * 4;
      if (idx == 0) begin
        if (it.pad_connected) begin
          b = it.button_bits & BUTTON_MASK;
          if ((it.left_trigger & TRIGGER_MASK) != 0) b[8] = 1'b1;
          if ((it.right_trigger & TRIGGER_MASK) != 0) b[9] = 1'b1;
          buttons[pad]   = ~b;
          sticks[base]   = axis_byte(it.left_x, dz_left);
          sticks[base+1] = axis_byte(it.left_y, dz_left);
          sticks[base+2] = axis_byte(it.right_x, dz_right);
          sticks[base+3] = axis_byte(it.right_y, dz_right);
        end else begin
          buttons[pad] = BUTTONS_UP;
          for (int i = 0; i < 4; i++) sticks[base+i] = STICK_CENTER;
        end
      end
      case (idx)
        0: return buttons[pad][7:0];
        1: return buttons[pad][15:8];
        2: return sticks[base+2];
        3: return 8'hff - sticks[base+3];
        4: return sticks[base];
        5: return 8'hff - sticks[base+1];
        default: return REPLY_IDLE;
      endcase
    endfunction

    // Reply of the latched command for data byte idx.
    function logic [7:0] command_reply(int unsigned idx, item_t it);
      logic [7:0] v;
      v = it.cmd_byte;
      case (cmd)
        CMD_QUERY_ANALOG: begin
          if (!native[pad]) return 8'd0;
          case (idx)
            0, 1: return 8'hff;
            2: return 8'd3;
            5: return CHAR_Z;
            default: return 8'd0;
          endcase
        end
        CMD_READ_DATA: return read_pad(idx, it);
        CMD_CONFIG: begin
          if (idx == 0) begin
            if (v == 8'd0) cfg_reads = 1'b0;
            else if (v == 8'd1) cfg_reads = 1'b1;
          end
          return cfg_reads ? read_pad(idx, it) : 8'd0;
        end
        CMD_SET_MODE: begin
          if (idx == 0) analog[pad] = (v == 8'd1);
          else if (idx == 1) locked[pad] = (v == 8'd3);
          return 8'd0;
        end
        CMD_QUERY_MODEL: begin
          case (idx)
            0: return 8'd1;
            1: return 8'd2;
            2: return analog[pad] ? 8'd1 : 8'd0;
            3: return native[pad] ? 8'd1 : 8'd2;
            4: return 8'd1;
            default: return 8'd0;
          endcase
        end
        CMD_VIBRATION: begin
          if (idx == 0) return v;
          if (idx == 1) begin
            vib_on[pad] = (v == 8'd1);
            return v;
          end
          return 8'hff;
        end
        CMD_NATIVE: begin
          if (idx == 5) begin
            native[pad] = 1'b1;
            return CHAR_Z;
          end
          return 8'd0;
        end
        default: return 8'd0;
      endcase
    endfunction

    // Called for every input beat the block accepts.
    function void note_beat(item_t it);
      logic [7:0] reply;
      if (it.action == ACT_START) begin
        pad    = it.pad_select % PAD_PORTS;
        pos    = 0;
        in_txn = 1'b1;
        reply  = REPLY_IDLE;
      end else if (!in_txn) begin
        reply = REPLY_IDLE;
      end else begin
        if (pos < 255) pos++;
        if (pos == 1) begin
          case (it.cmd_byte)
            CHAR_A:  cmd = CMD_QUERY_ANALOG;
            CHAR_B:  cmd = CMD_READ_DATA;
            CHAR_C:  cmd = CMD_CONFIG;
            CHAR_D:  cmd = CMD_SET_MODE;
            CHAR_E:  cmd = CMD_QUERY_MODEL;
            CHAR_M:  cmd = CMD_VIBRATION;
            CHAR_O:  cmd = CMD_NATIVE;
            default: cmd = CMD_UNKNOWN;
          endcase
          reply = analog[pad] ? (native[pad] ? ID_ANALOG_NAT : ID_ANALOG) : ID_DIGITAL;
        end else if (pos == 2) begin
          reply = CHAR_Z;
        end else begin
          reply = command_reply(pos - 3, it);
        end
      end
      replies_due.push_back(reply);
    endfunction

    // Called for every reply beat the block delivers.
    function void check_reply(logic [7:0] got);
      logic [7:0] want;
      checked++;
      if (replies_due.size() == 0) begin
        if (faults < 10) $display("ERROR: reply 0x%02h with no beat outstanding", got);
        faults++;
        return;
      end
      want = replies_due.pop_front();
      if (got !== want) begin
        if (faults < 10)
          $display("ERROR: reply_byte mismatch at reply %0d: expected 0x%02h, got 0x%02h",
                   checked, want, got);
        faults++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic [IN_USER_W-1:0]   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pad_reply_scoreboard sb = new();

  bit          steady_flow;
  int unsigned stall_left;
  int unsigned n_starts;
  int unsigned n_exchanges;
  int unsigned n_settings;

  game_pad_serial_command_responder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stick axis biased toward the full-scale ends and the deadzone edges.
  function automatic logic signed [15:0] pick_axis(input logic [CFG_DATA_W-1:0] dz);
    int d;
    d = int'(dz);
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(d - 1);
      3: return 16'(d);
      4: return 16'(-d);
      5: return 16'(1 - d);
      6: return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger();
    case ($urandom_range(0, 3))
      0: return 8'h1f;
      1: return 8'h20;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic item_t start_item(input logic p);
    item_t it;
    it            = '0;
    it.action     = ACT_START;
    it.pad_select = p;
    it.cmd_byte   = 8'($urandom());
    return it;
  endfunction

  // Exchange beat with random live pad inputs.
  function automatic item_t exchange_item(input logic [7:0] c);
    item_t it;
    it               = '0;
    it.action        = ACT_EXCHANGE;
    it.pad_select    = 1'($urandom());
    it.cmd_byte      = c;
    it.button_bits   = 16'($urandom());
    it.left_trigger  = pick_trigger();
    it.right_trigger = pick_trigger();
    it.left_x        = pick_axis(sb.dz_left);
    it.left_y        = pick_axis(sb.dz_left);
    it.right_x       = pick_axis(sb.dz_right);
    it.right_y       = pick_axis(sb.dz_right);
    it.pad_connected = ($urandom_range(0, 6) != 0);
    return it;
  endfunction

  // Data byte that steers the handlers that look at the console byte.
  function automatic logic [7:0] data_byte(input logic [7:0] c, input int unsigned idx);
    int unsigned r;
    r = $urandom_range(0, 2);
    if ((c == CHAR_D || c == CHAR_C) && idx == 0 && r != 2) return 8'(r);
    if (c == CHAR_D && idx == 1 && r != 2) return 8'd3;
    if (c == CHAR_M && idx == 1 && r != 2) return 8'(r);
    return 8'($urandom());
  endfunction

  // Present one input beat and wait for it to be taken.
  task automatic send_beat(input item_t it);
    int unsigned gap;
    if (!steady_flow && $urandom_range(0, 2) == 0) begin
      gap = idle_len();
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.pad_connected, it.right_y, it.right_x, it.left_y, it.left_x,
                 it.right_trigger, it.left_trigger, it.button_bits, it.cmd_byte};
    s_tuser  <= {it.pad_select, it.action};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(it);
    if (it.action == ACT_START) n_starts++;
    else n_exchanges++;
  endtask

  // Stop sending and wait until every reply is back, plus the pipeline depth.
  task automatic drain_replies();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LEFT_DEADZONE) sb.dz_left = val;
    else sb.dz_right = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One transaction: start, command byte, filler byte, then data bytes.
  task automatic run_transaction(input int unsigned n_bytes, input logic [7:0] c);
    for (int unsigned k = 0; k <= n_bytes; k++) begin
      if (k == 0) send_beat(start_item(1'($urandom())));
      else if (k == 1) send_beat(exchange_item(c));
      else if (k == 2) send_beat(exchange_item(8'($urandom())));
      else send_beat(exchange_item(data_byte(c, k - 3)));
    end
  endtask

  // Reply side: random stalls; none begins while the flow is steady.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Reply monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata);
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("game_pad_serial_command_responder test failed");
    $finish;
  end

  // Main sequence.
  initial begin
    item_t       it;
    logic [7:0]  cmds [7];
    int          left_dz [4];
    int          right_dz [4];
    int unsigned phase_start;
    logic [7:0]  c;
    int unsigned r;
    int unsigned len;
    bit          drained;

    cmds        = '{CHAR_A, CHAR_B, CHAR_C, CHAR_D, CHAR_E, CHAR_M, CHAR_O};
    left_dz     = '{0, 32767, $urandom_range(0, 32767), 1};
    right_dz    = '{0, 32767, $urandom_range(0, 32767), 32766};
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    steady_flow = 1'b0;
    stall_left  = 0;
    n_starts    = 0;
    n_exchanges = 0;
    n_settings  = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: exchange before any start replies idle and changes nothing.
    send_beat(exchange_item(CHAR_B));
    // Read data on pad 0 with a full-scale left stick, deadzone-edge right stick and trigger thresholds.
    send_beat(start_item(1'b0));
    send_beat(exchange_item(CHAR_B));
    send_beat(exchange_item(8'h00));
    it               = exchange_item(8'hff);
    it.button_bits   = 16'hffff;
    it.left_trigger  = 8'h20;
    it.right_trigger = 8'h1f;
    it.left_x        = 16'sh7fff;
    it.left_y        = 16'sh8000;
    it.right_x       = 16'(int'(RIGHT_DEADZONE_RST) - 1);
    it.right_y       = 16'(-int'(RIGHT_DEADZONE_RST));
    it.pad_connected = 1'b1;
    send_beat(it);
    for (int i = 0; i < 3; i++) send_beat(exchange_item(8'($urandom())));
    // Pad 1 to digital mode and locked.
    send_beat(start_item(1'b1));
    send_beat(exchange_item(CHAR_D));
    send_beat(exchange_item(8'h00));
    send_beat(exchange_item(8'h00));
    send_beat(exchange_item(8'h03));
    // Config mode turning data reads on, with the pad unplugged.
    send_beat(start_item(1'b1));
    send_beat(exchange_item(CHAR_C));
    send_beat(exchange_item(8'h00));
    it               = exchange_item(8'h01);
    it.pad_connected = 1'b0;
    send_beat(it);
    send_beat(exchange_item(8'($urandom())));
    // Vibration setup echoing its first two data bytes.
    send_beat(start_item(1'b0));
    send_beat(exchange_item(CHAR_M));
    send_beat(exchange_item(8'h00));
    send_beat(exchange_item(8'hab));
    send_beat(exchange_item(8'h01));
    send_beat(exchange_item(8'h07));

    // Random phases, the first at the reset deadzones.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain_replies();
        write_reg(REG_LEFT_DEADZONE, CFG_DATA_W'(left_dz[ph-1]));
        write_reg(REG_RIGHT_DEADZONE, CFG_DATA_W'(right_dz[ph-1]));
        n_settings++;
      end
      // Runs past the saturating byte position.
      if (ph == 1) run_transaction(262, CHAR_B);
      if (ph == 3) run_transaction(262, CHAR_A);
      phase_start = n_starts + n_exchanges;
      drained     = 1'b0;
      while (n_starts + n_exchanges - phase_start < 240) begin
        if ($urandom_range(0, 9) == 0) steady_flow = !steady_flow;
        if (!drained && n_starts + n_exchanges - phase_start >= 120) begin
          drain_replies();
          drained = 1'b1;
        end
        r = $urandom_range(0, 19);
        c = (r < 17) ? cmds[$urandom_range(0, 6)] : 8'($urandom());
        r = $urandom_range(0, 19);
        if (r < 12) len = $urandom_range(5, 9);
        else if (r < 17) len = $urandom_range(0, 4);
        else len = $urandom_range(10, 14);
        run_transaction(len, c);
      end
    end

    steady_flow = 1'b0;
    drain_replies();
    $display("Covered %0d start beats and %0d exchange beats over %0d deadzone settings;",
             n_starts, n_exchanges, n_settings);
    $display("%0d reply beats checked, %0d faults.", sb.checked, sb.faults);
    if (sb.faults == 0 && sb.replies_due.size() == 0) begin
      $display("game_pad_serial_command_responder test passed");
    end else begin
      $display("game_pad_serial_command_responder test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/gpsc_pkg.sv
hw/rtl/gpsc_stick_conv.sv
hw/rtl/gpsc_engine.sv
hw/rtl/game_pad_serial_command_responder.sv
sim/game_pad_serial_command_responder_test.sv
